[rtl/smm_pkg.sv]
package smm_pkg;

  localparam int MAX_ORDER = 8;
  localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int N_W       = IDX_W + 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
  localparam int CNT_W     = ADDR_W + 1;

  localparam int ORDER_W   = 4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = 35;
  localparam int IN_TDATA_W  = 2 * ELEM_W;
  localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              first_term;
    logic              last_term;
    logic              last_elem;
  } dp_cmd_t;

endpackage

[rtl/smm_ctrl.sv]
module smm_ctrl
  import smm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [ORDER_W-1:0] cfg_wr_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               busy,
  output dp_cmd_t            cmd
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]         state, state_next;
  logic [ORDER_W-1:0] order_in_use;
  logic [CNT_W-1:0]   load_count, load_count_next;
  logic [IDX_W-1:0]   row, row_next;
  logic [IDX_W-1:0]   col, col_next;
  logic [IDX_W-1:0]   term, term_next;
  logic [ADDR_W-1:0]  a_ptr, a_ptr_next;
  logic [ADDR_W-1:0]  b_ptr, b_ptr_next;
  logic [ADDR_W-1:0]  row_base, row_base_next;

  logic [N_W-1:0]     n;
  logic [IDX_W-1:0]   nm1;
  logic [CNT_W-1:0]   total;
  logic               elem_last;

  always_comb begin
    if (order_in_use == '0) begin
      n = N_W'(1);
    end else if (int'(order_in_use) > MAX_ORDER) begin
      n = N_W'(MAX_ORDER);
    end else begin
      n = N_W'(order_in_use);
    end
  end

  assign nm1       = IDX_W'(n - 1'b1);
  assign total     = CNT_W'(n) * CNT_W'(n);
  assign elem_last = (row == nm1) && (col == nm1);
  assign s_tready  = (state == ST_LOAD);

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    row_next        = row;
    col_next        = col;
    term_next       = term;
    a_ptr_next      = a_ptr;
    b_ptr_next      = b_ptr;
    row_base_next   = row_base;
    cmd             = '0;
    unique case (state)
      ST_LOAD: begin
        if (s_tvalid) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = load_count[ADDR_W-1:0];
          if (CNT_W'(load_count + 1'b1) == total) begin
            load_count_next = '0;
            row_next        = '0;
            col_next        = '0;
            term_next       = '0;
            a_ptr_next      = '0;
            b_ptr_next      = '0;
            row_base_next   = '0;
            state_next      = ST_ISSUE;
          end else begin
            load_count_next = load_count + 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        cmd.rd_en      = 1'b1;
        cmd.a_addr     = a_ptr;
        cmd.b_addr     = b_ptr;
        cmd.first_term = (term == '0);
        cmd.last_term  = (term == nm1);
        cmd.last_elem  = elem_last;
        a_ptr_next     = a_ptr + 1'b1;
        b_ptr_next     = b_ptr + ADDR_W'(n);
        term_next      = term + 1'b1;
        if (term == nm1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          if (elem_last) begin
            state_next = ST_LOAD;
          end else begin
            term_next  = '0;
            state_next = ST_ISSUE;
            if (col == nm1) begin
              col_next      = '0;
              row_next      = row + 1'b1;
              row_base_next = row_base + ADDR_W'(n);
              a_ptr_next    = row_base + ADDR_W'(n);
              b_ptr_next    = '0;
            end else begin
              col_next   = col + 1'b1;
              a_ptr_next = row_base;
              b_ptr_next = ADDR_W'(col) + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      order_in_use <= ORDER_RESET;
      load_count   <= '0;
      row          <= '0;
      col          <= '0;
      term         <= '0;
      a_ptr        <= '0;
      b_ptr        <= '0;
      row_base     <= '0;
    end else begin
      state    <= state_next;
      row      <= row_next;
      col      <= col_next;
      term     <= term_next;
      a_ptr    <= a_ptr_next;
      b_ptr    <= b_ptr_next;
      row_base <= row_base_next;
      if (cfg_wr_en) begin
        order_in_use <= cfg_wr_data;
        load_count   <= '0;
      end else begin
        load_count <= load_count_next;
      end
    end
  end

endmodule

[rtl/smm_dp.sv]
module smm_dp
  import smm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic signed [ELEM_W-1:0] a_element,
  input  logic signed [ELEM_W-1:0] b_element,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic signed [SUM_W-1:0]  product_element,
  output logic                     last_element,
  output logic                     busy
);

  logic signed [ELEM_W-1:0] left_store  [DEPTH];
  logic signed [ELEM_W-1:0] right_store [DEPTH];

  logic signed [ELEM_W-1:0] a_q, b_q;
  logic                     s1_valid, s1_first, s1_last, s1_elast;
  logic signed [PROD_W-1:0] prod;
  logic                     s2_valid, s2_first, s2_last, s2_elast;
  logic signed [SUM_W-1:0]  acc, acc_sum;

  assign acc_sum = s2_first ? SUM_W'(prod) : acc + SUM_W'(prod);
  assign busy    = s1_valid | s2_valid | m_tvalid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      left_store[cmd.wr_addr]  <= a_element;
      right_store[cmd.wr_addr] <= b_element;
    end
    if (cmd.rd_en) begin
      a_q <= left_store[cmd.a_addr];
      b_q <= right_store[cmd.b_addr];
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= cmd.first_term;
    s1_last  <= cmd.last_term;
    s1_elast <= cmd.last_elem;
    prod     <= a_q * b_q;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_elast <= s1_elast;
    if (s2_valid) begin
      acc <= acc_sum;
    end
    if (s2_valid && s2_last) begin
      product_element <= acc_sum;
      last_element    <= s2_elast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
      if (s2_valid && s2_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/square_matrix_multiply.sv]
// Square matrix multiplier, signed Q4.12 elements in, exact Q11.24 sums out.
// Slave stream: one transaction per position in row-major order, carrying
// the element of A and the element of B at that position. The slave side is
// ready only while the block is loading; one transaction per cycle.
// After the n*n-th transaction the block computes and sends every element
// of C = A * B in row-major order on the master stream, tlast on the final
// one. Each product element goes through one multiply-accumulate unit fed
// by one read port on each element store.
// The unit waits for each result to be taken before starting the next, so a
// stalled receiver simply holds the block; nothing is dropped.
// cfg_wr_en writes the order (0 acts as 1, above 8 acts as 8) and abandons
// any partial load; write it only while idle.
// Reset: synchronous, clears the load count and sets the order to 8.
module square_matrix_multiply
  import smm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [ORDER_W-1:0]     cfg_wr_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // a_element, b_element
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // product_element, zero pad
  output logic                   m_tlast   // last_element
);

  dp_cmd_t                  cmd;
  logic                     busy;
  logic signed [SUM_W-1:0]  product_element;

  smm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .busy        (busy),
    .cmd         (cmd)
  );

  smm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .a_element       (s_tdata[ELEM_W-1:0]),
    .b_element       (s_tdata[2*ELEM_W-1:ELEM_W]),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .product_element (product_element),
    .last_element    (m_tlast),
    .busy            (busy)
  );

  assign m_tdata = OUT_TDATA_W'(unsigned'(product_element));

`ifndef SYNTH
  a_load_excl_out: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("load accepted while a result is pending");

  a_read_not_loading: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !s_tready)
    else $error("store read during load");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !busy)
    else $error("store written while datapath busy");

  a_reset_load: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("not loading after reset");
`endif

endmodule
